// File: rtl/scsa_pkg.sv
`timescale 1ns / 1ps
package scsa_pkg;

   localparam int NUM_CLASSES = 8;
   localparam int STACK_DEPTH = 64;
   localparam int ADDR_WIDTH  = 48;

   // fixed field widths
   localparam int AW       = 48;
   localparam int SIZE_W   = 16;
   localparam int CLS_W    = 3;
   localparam int STATUS_W = 3;
   localparam int CSR_IDX_W = 8;
   localparam int NUM_CFG  = 8;
   localparam int OFF_W    = 12;
   localparam int CNT_W    = 7;

   localparam int TOP_W     = $clog2(STACK_DEPTH + 1);
   localparam int STK_IDX_W = $clog2(STACK_DEPTH);
   localparam int RAM_DEPTH = NUM_CLASSES * STACK_DEPTH;
   localparam int RAM_AW    = $clog2(RAM_DEPTH);

   localparam logic [AW-1:0] ADDR_MASK =
      (ADDR_WIDTH >= AW) ? {AW{1'b1}} : ((AW'(1) << ADDR_WIDTH) - AW'(1));

   localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
   localparam logic [STATUS_W-1:0] ST_TOO_LARGE   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_OUT_OF_MEM  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_MISALIGNED  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_OWNED   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_STACK_FULL  = 3'd5;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ALLOC_SCAN,
      S_ALLOC_POP,
      S_FREE_SCAN,
      S_DONE
   } scsa_state_type;

   typedef struct packed {
      logic [AW-1:0] op_a;
      logic [AW-1:0] op_b;
      logic          sub;
   } scsa_alu_req_type;

   typedef struct packed {
      logic [AW-1:0] sum;
      logic          no_borrow;
   } scsa_alu_rsp_type;

   function automatic logic [12:0] chunk_bytes(input logic [CLS_W-1:0] k);
      logic [12:0] r;
      case (k)
         3'd0:    r = 13'h0010;
         3'd1:    r = 13'h0020;
         3'd2:    r = 13'h0040;
         3'd3:    r = 13'h0080;
         3'd4:    r = 13'h0100;
         3'd5:    r = 13'h0200;
         3'd6:    r = 13'h0400;
         default: r = 13'h1000;
      endcase
      return r;
   endfunction

   function automatic logic [3:0] chunk_shift(input logic [CLS_W-1:0] k);
      logic [3:0] r;
      case (k)
         3'd0:    r = 4'd4;
         3'd1:    r = 4'd5;
         3'd2:    r = 4'd6;
         3'd3:    r = 4'd7;
         3'd4:    r = 4'd8;
         3'd5:    r = 4'd9;
         3'd6:    r = 4'd10;
         default: r = 4'd12;
      endcase
      return r;
   endfunction

   function automatic logic [CNT_W-1:0] capacity(input logic [CLS_W-1:0] k);
      logic [CNT_W-1:0] r;
      case (k)
         3'd0:    r = 7'h40;
         3'd1:    r = 7'h40;
         3'd2:    r = 7'h40;
         3'd3:    r = 7'h30;
         3'd4:    r = 7'h30;
         3'd5:    r = 7'h20;
         3'd6:    r = 7'h20;
         default: r = 7'h10;
      endcase
      return r;
   endfunction

   // region length in bytes: chunk size times capacity
   function automatic logic [16:0] region_bytes(input logic [CLS_W-1:0] k);
      logic [16:0] r;
      case (k)
         3'd0:    r = 17'h00400;
         3'd1:    r = 17'h00800;
         3'd2:    r = 17'h01000;
         3'd3:    r = 17'h01800;
         3'd4:    r = 17'h03000;
         3'd5:    r = 17'h04000;
         3'd6:    r = 17'h08000;
         default: r = 17'h10000;
      endcase
      return r;
   endfunction

endpackage

// File: rtl/scsa_if.sv
`timescale 1ns / 1ps
interface scsa_req_if;
   import scsa_pkg::*;
   logic                valid;
   logic                ready;
   logic                cmd;
   logic [SIZE_W-1:0]   req_size;
   logic [AW-1:0]       chunk_address;

   modport source (output valid, output cmd, output req_size, output chunk_address,
                   input ready);
   modport sink   (input valid, input cmd, input req_size, input chunk_address,
                   output ready);
endinterface

interface scsa_rsp_if;
   import scsa_pkg::*;
   logic                valid;
   logic                ready;
   logic [AW-1:0]       grant_address;
   logic [CLS_W-1:0]    class_index;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output grant_address, output class_index, output status,
                   input ready);
   modport sink   (input valid, input grant_address, input class_index, input status,
                   output ready);
endinterface

interface scsa_csr_if;
   import scsa_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [AW-1:0]        data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/size_class_slab_allocator_core.sv
`timescale 1ns / 1ps
// from transfer to result register: alloc scans the classes, one class a cycle, then pops
// the free stack if it has an entry; free scans the classes too; oversize alloc or null free skip the scan
// throughput: one request at a time, next one taken the cycle after the result is loaded;
// a stalled result register delays the load
// reset: synchronous, clears bump counts, stack tops and base registers; the stack memory
// needs no clearing since only entries below a stack top are read
module size_class_slab_allocator_core (
   input  logic      clock,
   input  logic      reset,
   scsa_req_if.sink  req,
   scsa_rsp_if.source rsp,
   scsa_csr_if.sink  csr
);
   import scsa_pkg::*;

   scsa_alu_req_type   alu_req;
   scsa_alu_rsp_type   alu_rsp;
   logic               ram_wr_en;
   logic [RAM_AW-1:0]  ram_wr_addr;
   logic [OFF_W-1:0]   ram_wr_data;
   logic [RAM_AW-1:0]  ram_rd_addr;
   logic [OFF_W-1:0]   ram_rd_data;

   assign csr.ready = 1'b1;

   scsa_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req.valid),
      .req_ready         (req.ready),
      .req_cmd           (req.cmd),
      .req_size          (req.req_size),
      .req_chunk_address (req.chunk_address),
      .rsp_valid         (rsp.valid),
      .rsp_ready         (rsp.ready),
      .rsp_grant_address (rsp.grant_address),
      .rsp_class_index   (rsp.class_index),
      .rsp_status        (rsp.status),
      .csr_valid         (csr.valid),
      .csr_index         (csr.index),
      .csr_data          (csr.data),
      .alu_req           (alu_req),
      .alu_rsp           (alu_rsp),
      .ram_wr_en         (ram_wr_en),
      .ram_wr_addr       (ram_wr_addr),
      .ram_wr_data       (ram_wr_data),
      .ram_rd_addr       (ram_rd_addr),
      .ram_rd_data       (ram_rd_data)
   );

   scsa_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   scsa_ram #(
      .WIDTH (OFF_W),
      .DEPTH (RAM_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );
endmodule

// File: rtl/scsa_ram.sv
`timescale 1ns / 1ps
module scsa_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: rtl/scsa_alu.sv
`timescale 1ns / 1ps
module scsa_alu (
   input  scsa_pkg::scsa_alu_req_type alu_req,
   output scsa_pkg::scsa_alu_rsp_type alu_rsp
);
   import scsa_pkg::*;

   logic [AW:0] full;

   // subtract as a + ~b + 1, carry out set means a >= b
   always_comb begin
      full = {1'b0, alu_req.op_a}
           + {1'b0, (alu_req.sub ? ~alu_req.op_b : alu_req.op_b)}
           + (AW + 1)'(alu_req.sub);
      alu_rsp.sum       = full[AW-1:0] & ADDR_MASK;
      alu_rsp.no_borrow = full[AW];
   end
endmodule

// File: rtl/scsa_ctrl.sv
`timescale 1ns / 1ps
module scsa_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   // request
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_cmd,
   input  logic [scsa_pkg::SIZE_W-1:0]    req_size,
   input  logic [scsa_pkg::AW-1:0]        req_chunk_address,
   // response
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [scsa_pkg::AW-1:0]        rsp_grant_address,
   output logic [scsa_pkg::CLS_W-1:0]     rsp_class_index,
   output logic [scsa_pkg::STATUS_W-1:0]  rsp_status,
   // register writes
   input  logic                           csr_valid,
   input  logic [scsa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [scsa_pkg::AW-1:0]        csr_data,
   // shared adder
   output scsa_pkg::scsa_alu_req_type     alu_req,
   input  scsa_pkg::scsa_alu_rsp_type     alu_rsp,
   // free stack memory
   output logic                           ram_wr_en,
   output logic [scsa_pkg::RAM_AW-1:0]    ram_wr_addr,
   output logic [scsa_pkg::OFF_W-1:0]     ram_wr_data,
   output logic [scsa_pkg::RAM_AW-1:0]    ram_rd_addr,
   input  logic [scsa_pkg::OFF_W-1:0]     ram_rd_data
);
   import scsa_pkg::*;

   localparam logic [CLS_W-1:0] LAST_CLS = CLS_W'(NUM_CLASSES - 1);

   scsa_state_type    state_ff, state_in;
   logic [CLS_W-1:0]  cls_ff, cls_in;
   logic [AW-1:0]     addr_ff, addr_in;
   logic [AW-1:0]     base_ff [NUM_CFG];
   logic [CNT_W-1:0]  bump_ff [NUM_CLASSES];
   logic [CNT_W-1:0]  bump_in [NUM_CLASSES];
   logic [TOP_W-1:0]  top_ff  [NUM_CLASSES];
   logic [TOP_W-1:0]  top_in  [NUM_CLASSES];
   logic [AW-1:0]     res_addr_ff, res_addr_in;
   logic [CLS_W-1:0]  res_cls_ff, res_cls_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0]     rsp_addr_ff, rsp_addr_in;
   logic [CLS_W-1:0]  rsp_cls_ff, rsp_cls_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic              start_found;
   logic [CLS_W-1:0]  start_cls;
   logic [TOP_W-1:0]  cur_top;
   logic [CNT_W-1:0]  cur_bump;
   logic              owned;

   function automatic logic [RAM_AW-1:0] stack_addr(input logic [CLS_W-1:0] k,
                                                    input logic [STK_IDX_W-1:0] idx);
      return RAM_AW'(int'(k) * STACK_DEPTH + int'(idx));
   endfunction

   // smallest class whose chunk fits the request
   always_comb begin
      start_found = 1'b0;
      start_cls   = '0;
      for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
         if (SIZE_W'(chunk_bytes(CLS_W'(i))) >= req_size) begin
            start_found = 1'b1;
            start_cls   = CLS_W'(i);
         end
      end
   end

   assign cur_top  = top_ff[cls_ff];
   assign cur_bump = bump_ff[cls_ff];
   assign owned    = alu_rsp.no_borrow && (alu_rsp.sum < AW'(region_bytes(cls_ff)));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            bump_ff[i] <= '0;
            top_ff[i]  <= '0;
         end
         for (int i = 0; i < NUM_CFG; i++) begin
            base_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         bump_ff      <= bump_in;
         top_ff       <= top_in;
         if (csr_valid && (csr_index < CSR_IDX_W'(NUM_CFG))) begin
            base_ff[csr_index[CLS_W-1:0]] <= csr_data & ADDR_MASK;
         end
      end
   end

   always_ff @(posedge clock) begin
      cls_ff        <= cls_in;
      addr_ff       <= addr_in;
      res_addr_ff   <= res_addr_in;
      res_cls_ff    <= res_cls_in;
      res_status_ff <= res_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_cls_ff    <= rsp_cls_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      cls_in        = cls_ff;
      addr_in       = addr_ff;
      bump_in       = bump_ff;
      top_in        = top_ff;
      res_addr_in   = res_addr_ff;
      res_cls_in    = res_cls_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_cls_in    = rsp_cls_ff;
      rsp_status_in = rsp_status_ff;
      req_ready     = 1'b0;
      alu_req.op_a  = base_ff[cls_ff];
      alu_req.op_b  = '0;
      alu_req.sub   = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = stack_addr(cls_ff, cur_top[STK_IDX_W-1:0]);
      ram_wr_data   = alu_rsp.sum[OFF_W+3:4];
      ram_rd_addr   = stack_addr(cls_ff, STK_IDX_W'(cur_top - TOP_W'(1)));

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            res_addr_in = '0;
            res_cls_in  = '0;
            if (req_valid) begin
               addr_in = req_chunk_address & ADDR_MASK;
               if (req_cmd == CMD_ALLOC) begin
                  cls_in = start_cls;
                  if (start_found) begin
                     state_in = S_ALLOC_SCAN;
                  end else begin
                     res_status_in = ST_TOO_LARGE;
                     state_in      = S_DONE;
                  end
               end else begin
                  cls_in = '0;
                  if ((req_chunk_address & ADDR_MASK) == '0) begin
                     res_status_in = ST_OK;
                     state_in      = S_DONE;
                  end else begin
                     state_in = S_FREE_SCAN;
                  end
               end
            end
         end
         S_ALLOC_SCAN: begin
            // bump address: base + (count << log2 chunk)
            alu_req.op_b = AW'(cur_bump) << chunk_shift(cls_ff);
            if (cur_top != '0) begin
               top_in[cls_ff] = cur_top - TOP_W'(1);
               state_in       = S_ALLOC_POP;
            end else if (cur_bump < capacity(cls_ff)) begin
               bump_in[cls_ff] = cur_bump + CNT_W'(1);
               res_addr_in     = alu_rsp.sum;
               res_cls_in      = cls_ff;
               res_status_in   = ST_OK;
               state_in        = S_DONE;
            end else if (cls_ff == LAST_CLS) begin
               res_status_in = ST_OUT_OF_MEM;
               state_in      = S_DONE;
            end else begin
               cls_in = cls_ff + CLS_W'(1);
            end
         end
         S_ALLOC_POP: begin
            alu_req.op_b  = AW'(ram_rd_data) << 4;
            res_addr_in   = alu_rsp.sum;
            res_cls_in    = cls_ff;
            res_status_in = ST_OK;
            state_in      = S_DONE;
         end
         S_FREE_SCAN: begin
            alu_req.op_a = addr_ff;
            alu_req.op_b = base_ff[cls_ff];
            alu_req.sub  = 1'b1;
            if (owned) begin
               res_cls_in = cls_ff;
               state_in   = S_DONE;
               if (addr_ff[3:0] != 4'h0) begin
                  res_status_in = ST_MISALIGNED;
               end else if (cur_top >= TOP_W'(STACK_DEPTH)) begin
                  res_status_in = ST_STACK_FULL;
               end else begin
                  ram_wr_en      = 1'b1;
                  top_in[cls_ff] = cur_top + TOP_W'(1);
                  res_status_in  = ST_OK;
               end
            end else if (cls_ff == LAST_CLS) begin
               res_status_in = ST_NOT_OWNED;
               state_in      = S_DONE;
            end else begin
               cls_in = cls_ff + CLS_W'(1);
            end
         end
         S_DONE: begin
            // hand off once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = res_addr_ff;
               rsp_cls_in    = res_cls_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_grant_address = rsp_addr_ff;
   assign rsp_class_index   = rsp_cls_ff;
   assign rsp_status        = rsp_status_ff;
endmodule

// File: rtl/scsa_checker.sv
`timescale 1ns / 1ps
module scsa_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [scsa_pkg::AW-1:0]       rsp_grant_address,
   input logic [scsa_pkg::CLS_W-1:0]    rsp_class_index,
   input logic [scsa_pkg::STATUS_W-1:0] rsp_status
);
   import scsa_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_grant_address)
         && $stable(rsp_class_index) && $stable(rsp_status))
      else $error("response changed while stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_STACK_FULL)
      else $error("unknown status code");

   a_fail_no_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_grant_address == '0)
      else $error("grant address on failure");
endmodule

bind size_class_slab_allocator_core scsa_checker u_scsa_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req.valid),
   .req_ready         (req.ready),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_grant_address (rsp.grant_address),
   .rsp_class_index   (rsp.class_index),
   .rsp_status        (rsp.status)
);

// File: test/slab_grant_checker.sv
`timescale 1ns / 1ps
module slab_grant_checker
   import scsa_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic                 req_cmd,
   input  logic [SIZE_W-1:0]    req_size,
   input  logic [AW-1:0]        req_chunk_address,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [AW-1:0]        rsp_grant_address,
   input  logic [CLS_W-1:0]     rsp_class_index,
   input  logic [STATUS_W-1:0]  rsp_status,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [AW-1:0]        csr_data,
   output int                   fail_count,
   output int                   open_count
);

   // class 7 first, class 0 last
   localparam logic [NUM_CLASSES-1:0][12:0] SLOT_BYTES =
      {13'h1000, 13'h400, 13'h200, 13'h100, 13'h80, 13'h40, 13'h20, 13'h10};
   localparam logic [NUM_CLASSES-1:0][CNT_W-1:0] SLOT_COUNT =
      {7'h10, 7'h20, 7'h20, 7'h30, 7'h30, 7'h40, 7'h40, 7'h40};

   typedef struct packed {
      logic [AW-1:0]       grant_address;
      logic [CLS_W-1:0]    class_index;
      logic [STATUS_W-1:0] status;
   } slab_grant_type;

   logic [AW-1:0]    class_base   [NUM_CLASSES];
   logic [CNT_W-1:0] bump_used    [NUM_CLASSES];
   logic [CNT_W-1:0] stack_fill   [NUM_CLASSES];
   logic [OFF_W-1:0] freed_offset [NUM_CLASSES][STACK_DEPTH];
   slab_grant_type   pending_grants [$];
   int               grants_seen;

   initial begin
      fail_count  = 0;
      open_count  = 0;
      grants_seen = 0;
   end

   function automatic slab_grant_type predict_grant(input logic cmd,
                                                    input logic [SIZE_W-1:0] size,
                                                    input logic [AW-1:0] addr);
      slab_grant_type r;
      int             k;
      bit             found;
      logic [AW-1:0]  off;
      r     = '0;
      k     = 0;
      found = 1'b0;
      if (cmd == CMD_ALLOC) begin
         while (k < NUM_CLASSES && SLOT_BYTES[k] < size)
            k++;
         if (k >= NUM_CLASSES) begin
            r.status = ST_TOO_LARGE;
         end else begin
            // recycled slots first, then fresh ones, then fall through to bigger classes
            while (k < NUM_CLASSES && !found) begin
               if (stack_fill[k] != '0) begin
                  stack_fill[k] = stack_fill[k] - 1'b1;
                  r.grant_address = (class_base[k] +
                     {freed_offset[k][stack_fill[k][STK_IDX_W-1:0]], 4'h0}) & ADDR_MASK;
                  found = 1'b1;
               end else if (bump_used[k] < SLOT_COUNT[k]) begin
                  r.grant_address = (class_base[k] + AW'(SLOT_BYTES[k]) * AW'(bump_used[k]))
                                    & ADDR_MASK;
                  bump_used[k] = bump_used[k] + 1'b1;
                  found = 1'b1;
               end
               if (found)
                  r.class_index = CLS_W'(k);
               else
                  k++;
            end
            r.status = found ? ST_OK : ST_OUT_OF_MEM;
         end
      end else if (addr != '0) begin
         // lowest class whose range holds the address owns it
         while (k < NUM_CLASSES && !found) begin
            if (addr >= class_base[k] &&
                (addr - class_base[k]) < AW'(SLOT_BYTES[k]) * AW'(SLOT_COUNT[k]))
               found = 1'b1;
            else
               k++;
         end
         if (!found) begin
            r.status = ST_NOT_OWNED;
         end else begin
            r.class_index = CLS_W'(k);
            off = addr - class_base[k];
            if (addr[3:0] != 4'h0) begin
               r.status = ST_MISALIGNED;
            end else if (stack_fill[k] >= CNT_W'(STACK_DEPTH)) begin
               r.status = ST_STACK_FULL;
            end else begin
               freed_offset[k][stack_fill[k][STK_IDX_W-1:0]] = off[OFF_W+3:4];
               stack_fill[k] = stack_fill[k] + 1'b1;
            end
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [AW-1:0] got,
                                  input logic [AW-1:0] want);
      $display("%0t: result %0d %s: got %0h, expected %0h", $time, grants_seen, what,
               got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin : watch_channels
      slab_grant_type want;
      if (reset) begin
         for (int k = 0; k < NUM_CLASSES; k++) begin
            class_base[k] = '0;
            bump_used[k]  = '0;
            stack_fill[k] = '0;
         end
         pending_grants.delete();
      end else begin
         // a result can never belong to a request taken in the same cycle
         if (rsp_valid && rsp_ready) begin
            if (pending_grants.size() == 0) begin
               report_mismatch("arrived with nothing outstanding", rsp_grant_address, '0);
            end else begin
               want = pending_grants.pop_front();
               if (rsp_grant_address !== want.grant_address)
                  report_mismatch("grant_address", rsp_grant_address, want.grant_address);
               if (rsp_class_index !== want.class_index)
                  report_mismatch("class_index", AW'(rsp_class_index), AW'(want.class_index));
               if (rsp_status !== want.status)
                  report_mismatch("status", AW'(rsp_status), AW'(want.status));
            end
            grants_seen++;
         end
         if (csr_valid && csr_ready && csr_index < NUM_CFG)
            class_base[csr_index[CLS_W-1:0]] = csr_data & ADDR_MASK;
         if (req_valid && req_ready)
            pending_grants.push_back(predict_grant(req_cmd, req_size, req_chunk_address));
      end
      open_count = pending_grants.size();
   end

endmodule

// File: test/size_class_slab_allocator_core_test.sv
`timescale 1ns / 1ps
module size_class_slab_allocator_core_test;
   import scsa_pkg::*;

   typedef enum int {MIX_TRAFFIC, DRAIN_CLASSES, REFILL_ONE_CLASS} traffic_mode_type;
   typedef enum int {LAYOUT_LOW, LAYOUT_SPREAD, LAYOUT_TOP, LAYOUT_OVERLAP} base_layout_type;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int ITEMS_PER_PHASE = 545;
   localparam int SETTLE_CYCLES   = 20;

   localparam logic [CSR_IDX_W-1:0] FIRST_UNUSED_CSR = CSR_IDX_W'(NUM_CFG);
   localparam logic [CSR_IDX_W-1:0] LAST_UNUSED_CSR  = '1;

   logic          clock;
   logic          reset;
   int            send_idle_pct;
   int            recv_stall_pct;
   int            cycle_count = 0;
   int            fail_count;
   int            open_count;
   logic [AW-1:0] region_base [NUM_CLASSES];

   scsa_req_if req_ch ();
   scsa_rsp_if rsp_ch ();
   scsa_csr_if csr_ch ();

   size_class_slab_allocator_core u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   slab_grant_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_ch.valid),
      .req_ready         (req_ch.ready),
      .req_cmd           (req_ch.cmd),
      .req_size          (req_ch.req_size),
      .req_chunk_address (req_ch.chunk_address),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_grant_address (rsp_ch.grant_address),
      .rsp_class_index   (rsp_ch.class_index),
      .rsp_status        (rsp_ch.status),
      .csr_valid         (csr_ch.valid),
      .csr_ready         (csr_ch.ready),
      .csr_index         (csr_ch.index),
      .csr_data          (csr_ch.data),
      .fail_count        (fail_count),
      .open_count        (open_count)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

   function automatic logic [SIZE_W-1:0] size_for_class(input int k);
      int lo;
      lo = (k == 0) ? 0 : int'(chunk_bytes(CLS_W'(k - 1))) + 1;
      return SIZE_W'($urandom_range(int'(chunk_bytes(CLS_W'(k))), lo));
   endfunction

   function automatic logic [AW-1:0] slot_address(input int k);
      return region_base[k] + AW'(chunk_bytes(CLS_W'(k))) *
             AW'($urandom_range(int'(capacity(CLS_W'(k))) - 1));
   endfunction

   // leaves valid high; the caller lowers it after the last write
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [AW-1:0] value);
      csr_ch.valid = 1'b1;
      csr_ch.index = idx;
      csr_ch.data  = value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      if (idx < NUM_CFG)
         region_base[idx] = value;
      @(negedge clock);
   endtask

   task automatic load_layout(input base_layout_type layout);
      logic [AW-1:0] origin;
      logic [AW-1:0] upper;
      logic [AW-1:0] value;
      origin = {32'($urandom_range(32'hFFFF_FFF0)), 16'h0000};
      upper  = {32'($urandom_range(32'hFFFF_FFF0)), 16'h0000};
      for (int k = 0; k < NUM_CLASSES; k++) begin
         case (layout)
            LAYOUT_LOW: begin
               value = AW'(k) << 16;
            end
            LAYOUT_SPREAD: begin
               value = origin + (AW'(k) << 16);
            end
            LAYOUT_TOP: begin
               // the upper classes run into the end of the address space and overlap
               if (k == 5)
                  value = '1;
               else if (k == 6)
                  value = 48'hFFFF_FFFF_C000;
               else if (k == 7)
                  value = 48'hFFFF_FFFF_F000;
               else
                  value = 48'hFFFF_FFF8_0000 + (AW'(k) << 16);
            end
            default: begin
               // shared base for the small classes, unaligned bases for the big ones
               if (k < 4)
                  value = origin;
               else
                  value = upper + (AW'(k) << 16) + AW'($urandom_range(4095, 1));
            end
         endcase
         write_csr(CSR_IDX_W'(k), value);
      end
      if (layout != LAYOUT_LOW) begin
         write_csr(FIRST_UNUSED_CSR, AW'({$urandom, $urandom}));
         write_csr(LAST_UNUSED_CSR, AW'({$urandom, $urandom}));
      end
      csr_ch.valid = 1'b0;
   endtask

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_request(input logic cmd, input logic [SIZE_W-1:0] size,
                               input logic [AW-1:0] addr);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid         = 1'b1;
      req_ch.cmd           = cmd;
      req_ch.req_size      = size;
      req_ch.chunk_address = addr;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      @(negedge clock);
   endtask

   task automatic wait_all_granted();
      req_ch.valid = 1'b0;
      while (open_count != 0)
         @(negedge clock);
   endtask

   task automatic run_directed();
      send_request(CMD_ALLOC, 16'd0, '1);
      send_request(CMD_ALLOC, 16'd16, '0);
      send_request(CMD_ALLOC, 16'd17, '1);
      send_request(CMD_ALLOC, 16'd1024, '0);
      send_request(CMD_ALLOC, 16'd1025, '1);
      send_request(CMD_ALLOC, 16'd4096, '0);
      send_request(CMD_ALLOC, 16'd4097, '1);
      send_request(CMD_ALLOC, 16'hFFFF, '1);
      send_request(CMD_FREE, '1, '0);
      send_request(CMD_FREE, '0, region_base[0] + 48'h10);
      send_request(CMD_ALLOC, 16'd5, '0);
      send_request(CMD_FREE, '1, region_base[0] + 48'h13);
      send_request(CMD_FREE, '0, region_base[3] + 48'h1800);
      send_request(CMD_FREE, '1, region_base[7] + 48'h20);
      send_request(CMD_FREE, '0, region_base[7] + 48'h20);
      send_request(CMD_ALLOC, 16'd2048, '0);
      send_request(CMD_FREE, '1, '1);
      send_request(CMD_FREE, '0, region_base[6] + 48'h7C00);
   endtask

   task automatic random_request(input traffic_mode_type mode, input int hot);
      logic              cmd;
      logic [SIZE_W-1:0] size;
      logic [AW-1:0]     addr;
      int                pick;
      int                k;
      int                alloc_pct;
      case (mode)
         DRAIN_CLASSES:    alloc_pct = 90;
         REFILL_ONE_CLASS: alloc_pct = 10;
         default:          alloc_pct = 55;
      endcase
      cmd  = ($urandom_range(99) < alloc_pct) ? CMD_ALLOC : CMD_FREE;
      size = SIZE_W'($urandom);
      addr = AW'({$urandom, $urandom});
      pick = $urandom_range(99);
      if (cmd == CMD_ALLOC) begin
         if (pick < 4) begin
            size = SIZE_W'($urandom_range(65535, 4097));
         end else if (pick < 7) begin
            size = '0;
         end else begin
            k = (mode == DRAIN_CLASSES && pick < 60) ? $urandom_range(7, 5) : $urandom_range(7);
            size = size_for_class(k);
         end
      end else begin
         k = (mode == REFILL_ONE_CLASS) ? hot : $urandom_range(7);
         // below 5 frees address zero; 5 to 9 keeps the fully random address, mostly unowned
         if (pick < 5)
            addr = '0;
         else if (pick < 10)
            addr = addr;
         else if (pick < 17)
            addr = slot_address(k) + AW'($urandom_range(15, 1));
         else if (pick < 22)
            addr = pick[0] ? region_base[k] + AW'(region_bytes(CLS_W'(k)))
                           : region_base[k] - AW'(16);
         else
            addr = slot_address(k);
      end
      send_request(cmd, size, addr);
   endtask

   // segments of one traffic mix each: balanced, draining the classes or refilling one stack
   task automatic run_traffic(input int count);
      traffic_mode_type mode;
      int               sent;
      int               left;
      int               hot;
      sent = 0;
      while (sent < count) begin
         case ($urandom_range(3))
            0:       mode = DRAIN_CLASSES;
            1:       mode = REFILL_ONE_CLASS;
            default: mode = MIX_TRAFFIC;
         endcase
         left = (mode == REFILL_ONE_CLASS) ? $urandom_range(120, 60) : $urandom_range(90, 30);
         hot  = $urandom_range(7);
         while (left > 0 && sent < count) begin
            random_request(mode, hot);
            left--;
            sent++;
         end
      end
   endtask

   initial begin
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.cmd           = CMD_ALLOC;
      req_ch.req_size      = '0;
      req_ch.chunk_address = '0;
      csr_ch.valid         = 1'b0;
      csr_ch.index         = '0;
      csr_ch.data          = '0;
      rsp_ch.ready         = 1'b0;
      send_idle_pct        = 30;
      recv_stall_pct       = 82;
      for (int k = 0; k < NUM_CLASSES; k++)
         region_base[k] = '0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      load_layout(LAYOUT_LOW);
      run_directed();
      wait_all_granted();
      load_layout(LAYOUT_SPREAD);
      run_traffic(ITEMS_PER_PHASE);

      wait_all_granted();
      send_idle_pct  = 82;
      recv_stall_pct = 30;
      load_layout(LAYOUT_TOP);
      run_traffic(ITEMS_PER_PHASE);

      wait_all_granted();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      load_layout(LAYOUT_OVERLAP);
      run_traffic(ITEMS_PER_PHASE);

      wait_all_granted();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// File: filelist.f
rtl/scsa_pkg.sv
rtl/scsa_if.sv
rtl/scsa_ram.sv
rtl/scsa_alu.sv
rtl/scsa_ctrl.sv
rtl/size_class_slab_allocator_core.sv
rtl/scsa_checker.sv
test/slab_grant_checker.sv
test/size_class_slab_allocator_core_test.sv
